// File: hw/rtl/hyq_pkg.sv
// Shared types, constants and the arctangent table for the heading and yaw quaternion block.
package hyq_pkg;

  // Field width of each coordinate port and of the heading result.
  localparam int unsigned FieldW   = 16;
  // Direction vectors are scaled to about 2^ScaleExp before vectoring.
  localparam int unsigned ScaleExp = 40;
  // CORDIC x/y datapath width: 2^40 magnitude, gain and pre-turn headroom.
  localparam int unsigned DatW     = 44;
  // CORDIC angle accumulator width, Q.16 radians.
  localparam int unsigned AngW     = 20;

  localparam logic signed [FieldW-1:0] PiQ13     = 16'sd25736;
  localparam logic signed [FieldW-1:0] HalfPiQ13 = 16'sd12868;
  localparam logic signed [AngW-1:0]   HalfPiQ16 = 20'sd102944;
  localparam logic signed [DatW-1:0]   KQ30      = 44'sd652032874;
  localparam logic signed [FieldW-1:0] QuatMax   = 16'sd32767;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_VEC,
    ST_HEAD,
    ST_LOADR,
    ST_ROT,
    ST_FIN
  } hyq_state_e;

  // Control from the sequencer to the shared CORDIC unit.
  typedef struct packed {
    logic load;
    logic step;
    logic vec_mode;
  } hyq_ctrl_t;

  // round(atan(2^-i) * 2^16); zero from i = 17 on.
  function automatic logic signed [AngW-1:0] atan_q16(input logic [4:0] idx);
    logic signed [AngW-1:0] v;
    case (idx)
      5'd0:    v = 20'sd51472;
      5'd1:    v = 20'sd30386;
      5'd2:    v = 20'sd16055;
      5'd3:    v = 20'sd8150;
      5'd4:    v = 20'sd4091;
      5'd5:    v = 20'sd2047;
      5'd6:    v = 20'sd1024;
      5'd7:    v = 20'sd512;
      5'd8:    v = 20'sd256;
      5'd9:    v = 20'sd128;
      5'd10:   v = 20'sd64;
      5'd11:   v = 20'sd32;
      5'd12:   v = 20'sd16;
      5'd13:   v = 20'sd8;
      5'd14:   v = 20'sd4;
      5'd15:   v = 20'sd2;
      5'd16:   v = 20'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: hw/rtl/hyq_cordic_unit.sv
// Shared CORDIC micro-rotation unit: x/y/z registers, iteration counter, one step per cycle while ctrl step is high.
module hyq_cordic_unit #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  hyq_pkg::hyq_ctrl_t                  ctrl_i,
  input  logic signed [hyq_pkg::DatW-1:0]     x_init_i,
  input  logic signed [hyq_pkg::DatW-1:0]     y_init_i,
  input  logic signed [hyq_pkg::AngW-1:0]     z_init_i,
  output logic signed [hyq_pkg::DatW-1:0]     x_o,
  output logic signed [hyq_pkg::DatW-1:0]     y_o,
  output logic signed [hyq_pkg::AngW-1:0]     z_o,
  output logic                                last_o
);

  localparam int unsigned CntW = $clog2(CORDIC_STEPS);

  logic signed [hyq_pkg::DatW-1:0] x_q, x_d, y_q, y_d, xs, ys;
  logic signed [hyq_pkg::AngW-1:0] z_q, z_d, atan_v;
  logic [CntW-1:0]                 cnt_q, cnt_d;
  logic                            up;

  assign xs     = x_q >>> cnt_q;
  assign ys     = y_q >>> cnt_q;
  assign atan_v = hyq_pkg::atan_q16(5'(cnt_q));

  // Vectoring drives y toward zero, rotation drives z toward zero.
  assign up = ctrl_i.vec_mode ? (y_q[hyq_pkg::DatW-1] || (y_q == '0))
                              : !z_q[hyq_pkg::AngW-1];

  always_comb begin
    x_d   = x_q;
    y_d   = y_q;
    z_d   = z_q;
    cnt_d = cnt_q;
    if (ctrl_i.load) begin
      x_d   = x_init_i;
      y_d   = y_init_i;
      z_d   = z_init_i;
      cnt_d = '0;
    end else if (ctrl_i.step) begin
      if (up) begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - atan_v;
      end else begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + atan_v;
      end
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;
  assign last_o = (cnt_q == CntW'(CORDIC_STEPS - 1));

endmodule

// File: hw/rtl/heading_to_yaw_quaternion.sv
// Top level: leg heading (atan2) and yaw quaternion from two waypoints.
// Usage and flow: one leg is taken on the input channel as a beat of start
// and end coordinates. The block then goes busy (in_ready_o low) and works
// through two CORDIC passes on a single shared add/shift unit, one
// micro-rotation per clock. A general direction is prepared and loaded,
// vectored, its heading formed and reloaded, then rotated, and the result
// is rounded and captured. Axis-aligned and zero directions skip vectoring.
// The block returns to idle before it accepts the next leg, so a new leg
// cannot start while one is in flight. A finished result sits in an output
// register, so the next leg is accepted while the last result still waits;
// the rounding step holds until that register is free. A zero direction
// reuses the last heading and flags held_o; that heading resets to zero.
// Straight left yields +pi, never -pi. quat_w_o is clamped at zero.
module heading_to_yaw_quaternion #(
  parameter int unsigned CORDIC_STEPS = 16,
  parameter int unsigned COORD_BITS   = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [hyq_pkg::FieldW-1:0]   start_x_i,
  input  logic signed [hyq_pkg::FieldW-1:0]   start_y_i,
  input  logic signed [hyq_pkg::FieldW-1:0]   end_x_i,
  input  logic signed [hyq_pkg::FieldW-1:0]   end_y_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [hyq_pkg::FieldW-1:0]   heading_o,
  output logic [hyq_pkg::FieldW-2:0]          quat_w_o,
  output logic signed [hyq_pkg::FieldW-1:0]   quat_z_o,
  output logic                                held_o
);

  localparam int unsigned FW   = hyq_pkg::FieldW;
  localparam int unsigned DW   = hyq_pkg::DatW;
  localparam int unsigned AW   = hyq_pkg::AngW;
  localparam int unsigned RndW = DW - 15;

  hyq_pkg::hyq_state_e state_q, state_d;
  hyq_pkg::hyq_ctrl_t  ctrl;

  // Captured coordinates of the leg in flight.
  logic [FW-1:0] sx_q, sy_q, ex_q, ey_q;

  logic signed [FW-1:0] head_q, head_d, last_q;
  logic                 held_q, held_d;
  logic signed [FW-1:0] out_head_q, out_z_q;
  logic [FW-2:0]        out_w_q;
  logic                 out_held_q;
  logic                 out_valid_q;

  // Coordinates as COORD_BITS two's complement, then the direction.
  logic signed [COORD_BITS-1:0] sxc, syc, exc, eyc;
  logic signed [COORD_BITS:0]   dx, dy;
  logic signed [DW-1:0]         dxs, dys;
  logic                         dx_zero, dy_zero, dx_neg, dy_neg;

  assign sxc = COORD_BITS'({{(32 - FW){1'b0}}, sx_q});
  assign syc = COORD_BITS'({{(32 - FW){1'b0}}, sy_q});
  assign exc = COORD_BITS'({{(32 - FW){1'b0}}, ex_q});
  assign eyc = COORD_BITS'({{(32 - FW){1'b0}}, ey_q});
  assign dx  = (COORD_BITS + 1)'(exc) - (COORD_BITS + 1)'(sxc);
  assign dy  = (COORD_BITS + 1)'(eyc) - (COORD_BITS + 1)'(syc);
  assign dxs = DW'(dx) <<< (hyq_pkg::ScaleExp - COORD_BITS);
  assign dys = DW'(dy) <<< (hyq_pkg::ScaleExp - COORD_BITS);

  assign dx_zero = (dx == '0);
  assign dy_zero = (dy == '0);
  assign dx_neg  = dx[COORD_BITS];
  assign dy_neg  = dy[COORD_BITS];

  // Shared CORDIC unit.
  logic signed [DW-1:0] x_init, y_init, cx, cy;
  logic signed [AW-1:0] z_init, cz;
  logic                 c_last;

  hyq_cordic_unit #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .x_init_i(x_init),
    .y_init_i(y_init),
    .z_init_i(z_init),
    .x_o     (cx),
    .y_o     (cy),
    .z_o     (cz),
    .last_o  (c_last)
  );

  // Heading from the vectoring angle: (z + 4) >>> 3, clamped to +-pi.
  logic signed [AW:0]   z_rnd;
  logic signed [AW-3:0] z_q13;
  logic signed [FW-1:0] head_vec;

  assign z_rnd = (AW + 1)'(cz) + (AW + 1)'(4);
  assign z_q13 = (AW - 2)'(z_rnd >>> 3);
  always_comb begin
    if (z_q13 > (AW - 2)'(hyq_pkg::PiQ13)) begin
      head_vec = hyq_pkg::PiQ13;
    end else if (z_q13 < -(AW - 2)'(hyq_pkg::PiQ13)) begin
      head_vec = -hyq_pkg::PiQ13;
    end else begin
      head_vec = FW'(z_q13);
    end
  end

  // Quaternion parts from the rotation pass: (v + 2^14) >>> 15, clamped.
  logic signed [DW-1:0]   x_rnd_full, y_rnd_full;
  logic signed [RndW-1:0] x_rnd, y_rnd;
  logic [FW-2:0]          w_sat;
  logic signed [FW-1:0]   z_sat;

  assign x_rnd_full = cx + DW'(16384);
  assign y_rnd_full = cy + DW'(16384);
  assign x_rnd      = RndW'(x_rnd_full >>> 15);
  assign y_rnd      = RndW'(y_rnd_full >>> 15);

  always_comb begin
    if (x_rnd[RndW-1]) begin
      w_sat = '0;
    end else if (x_rnd > RndW'(hyq_pkg::QuatMax)) begin
      w_sat = '1;
    end else begin
      w_sat = (FW - 1)'(x_rnd);
    end
    if (y_rnd > RndW'(hyq_pkg::QuatMax)) begin
      z_sat = hyq_pkg::QuatMax;
    end else if (y_rnd < -RndW'(hyq_pkg::QuatMax)) begin
      z_sat = -hyq_pkg::QuatMax;
    end else begin
      z_sat = FW'(y_rnd);
    end
  end

  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  // Sequencer: next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      hyq_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = hyq_pkg::ST_PREP;
      end
      hyq_pkg::ST_PREP: begin
        if (dx_zero || dy_zero) state_d = hyq_pkg::ST_LOADR;
        else                    state_d = hyq_pkg::ST_VEC;
      end
      hyq_pkg::ST_VEC: begin
        if (c_last) state_d = hyq_pkg::ST_HEAD;
      end
      hyq_pkg::ST_HEAD:  state_d = hyq_pkg::ST_LOADR;
      hyq_pkg::ST_LOADR: state_d = hyq_pkg::ST_ROT;
      hyq_pkg::ST_ROT: begin
        if (c_last) state_d = hyq_pkg::ST_FIN;
      end
      hyq_pkg::ST_FIN: begin
        if (out_free) state_d = hyq_pkg::ST_IDLE;
      end
      default: state_d = hyq_pkg::ST_IDLE;
    endcase
  end

  // Sequencer: unit control, unit load values and the heading register.
  always_comb begin
    ctrl   = '0;
    x_init = hyq_pkg::KQ30;
    y_init = '0;
    z_init = AW'(head_q) <<< 2;
    head_d = head_q;
    held_d = held_q;
    case (state_q)
      hyq_pkg::ST_PREP: begin
        held_d = 1'b0;
        if (dx_zero && dy_zero) begin
          head_d = last_q;
          held_d = 1'b1;
        end else if (dx_zero) begin
          head_d = dy_neg ? -hyq_pkg::HalfPiQ13 : hyq_pkg::HalfPiQ13;
        end else if (dy_zero) begin
          head_d = dx_neg ? hyq_pkg::PiQ13 : '0;
        end else begin
          ctrl.load = 1'b1;
          // Turn a left-half-plane vector by 90 degrees so CORDIC converges.
          if (!dx_neg) begin
            x_init = dxs;
            y_init = dys;
            z_init = '0;
          end else if (!dy_neg) begin
            x_init = dys;
            y_init = -dxs;
            z_init = hyq_pkg::HalfPiQ16;
          end else begin
            x_init = -dys;
            y_init = dxs;
            z_init = -hyq_pkg::HalfPiQ16;
          end
        end
      end
      hyq_pkg::ST_VEC: begin
        ctrl.step     = 1'b1;
        ctrl.vec_mode = 1'b1;
      end
      hyq_pkg::ST_HEAD:  head_d = head_vec;
      hyq_pkg::ST_LOADR: ctrl.load = 1'b1;
      hyq_pkg::ST_ROT:   ctrl.step = 1'b1;
      default: ;
    endcase
  end

  assign in_ready_o = (state_q == hyq_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hyq_pkg::ST_IDLE;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // Advance the remembered heading unless this leg reused it.
      if (state_q == hyq_pkg::ST_LOADR && !held_q) last_q <= head_q;
      if (state_q == hyq_pkg::ST_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      sx_q <= start_x_i;
      sy_q <= start_y_i;
      ex_q <= end_x_i;
      ey_q <= end_y_i;
    end
    head_q <= head_d;
    held_q <= held_d;
    if (state_q == hyq_pkg::ST_FIN && out_free) begin
      out_head_q <= head_q;
      out_w_q    <= w_sat;
      out_z_q    <= z_sat;
      out_held_q <= held_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign heading_o   = out_head_q;
  assign quat_w_o    = out_w_q;
  assign quat_z_o    = out_z_q;
  assign held_o      = out_held_q;

endmodule

// File: hw/rtl/hyq_checker.sv
// Port-level checker for the heading and yaw quaternion block, with its bind.
module hyq_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic signed [hyq_pkg::FieldW-1:0]  heading_o,
  input logic signed [hyq_pkg::FieldW-1:0]  quat_z_o,
  input logic                               held_o
);

  // A stalled result beat stays valid and holds its heading, quat_z and held flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(heading_o)
      && $stable(quat_z_o) && $stable(held_o))
    else $error("result beat changed while stalled");

  // One leg at a time: busy right after an input beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a leg is in flight");

  // Heading stays within -pi..+pi.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (heading_o <= hyq_pkg::PiQ13) && (heading_o >= -hyq_pkg::PiQ13))
    else $error("heading out of range");

  // Quaternion z is clamped symmetric.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (quat_z_o <= hyq_pkg::QuatMax) && (quat_z_o >= -hyq_pkg::QuatMax))
    else $error("quat_z out of range");

endmodule

bind heading_to_yaw_quaternion hyq_checker u_hyq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .heading_o  (heading_o),
  .quat_z_o   (quat_z_o),
  .held_o     (held_o)
);
